// ===== design/byte_deque_with_indexed_read_defines.svh =====
// Assertion macros shared by the checker files of the byte deque.
// Depends on nothing; every macro expects i_clk and i_rst_n in scope.
`ifndef BYTE_DEQUE_WITH_INDEXED_READ_DEFINES_SVH
`define BYTE_DEQUE_WITH_INDEXED_READ_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
// Shared types and constants of the byte deque.
// Depends on nothing; imported by the top level, the checker and the bench.
package bdq_pkg;

    localparam int BDQ_DEPTH = 256;                 // ring buffer entries
    localparam int BDQ_AW    = $clog2(BDQ_DEPTH);   // pointer width
    localparam int BDQ_CW    = 9;                   // count field width
    localparam int BDQ_BW    = 8;                   // byte width
    localparam int BDQ_IN_W  = 16;                  // push_byte, position
    localparam int BDQ_OP_W  = 3;
    localparam int BDQ_OUT_W = 24;                  // 20 bits of fields, byte padded

    typedef enum logic [BDQ_OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Result layout, lowest field in the lowest bits.
    typedef struct packed {
        logic                is_empty;
        logic [BDQ_CW-1:0]   count_now;
        t_status             status;
        logic [BDQ_BW-1:0]   read_byte;
    } t_result;

    localparam int BDQ_RES_W = $bits(t_result);

endpackage

// ===== design/bdq_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];   // held until the next read
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/byte_deque_with_indexed_read.sv =====
// Byte deque top level: request decode, pointer and count update, result path.
// Depends on bdq_pkg and bdq_ram.
//
// A bounded double-ended queue of 256 bytes kept as a ring buffer in one
// single-port RAM. Each request on the slave stream carries an opcode in
// tuser (push front, push back, pop front, pop back, read at position,
// clear) and returns exactly one result on the master stream: the byte
// popped or read, a status (ok, empty on pop, position out of range, full
// on push), the count after the request and an empty flag. Failed requests
// leave the state untouched; a push into a full store is dropped. Every
// request makes at most one RAM access, so one request is taken per clock
// while results are being drained; a result passes from the RAM read register
// and stage 1 into the output register once that register is free or drained.
// The front pointer and count sit in flip-flops, so back-to-back accesses
// never conflict in the RAM; a write committed at one edge is seen by a
// read issued in the next cycle. No clearing pass after reset: entries are
// only read once a push has written them.
module byte_deque_with_indexed_read
    import bdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [BDQ_IN_W-1:0]  i_s_axis_tdata,   // [7:0] push_byte, [15:8] position
    input  logic [BDQ_OP_W-1:0]  i_s_axis_tuser,   // [2:0] opcode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [BDQ_OUT_W-1:0] o_m_axis_tdata    // [7:0] read_byte, [9:8] status,
                                                    // [18:10] count_now, [19] is_empty
);

    localparam logic [BDQ_CW-1:0] CountFull = BDQ_CW'(BDQ_DEPTH);

    // Architectural state
    logic [BDQ_AW-1:0] r_front, n_front;
    logic [BDQ_CW-1:0] r_count, n_count;

    // Stage 1: request issued to the RAM, read data arrives next cycle
    logic              r_s1_valid;
    t_status           r_s1_status;
    logic [BDQ_CW-1:0] r_s1_count;
    logic              r_s1_use_rd;

    // Output register
    logic              r_out_valid;
    t_result           r_out;

    // Request fields
    t_op               req_op;
    logic [BDQ_BW-1:0] req_byte;
    logic [BDQ_BW-1:0] req_pos;
    logic [BDQ_CW-1:0] req_pos_ext;

    logic              accept;
    logic              advance;
    logic              is_full;
    logic              is_none;
    t_status           n_status;
    logic              n_use_rd;

    // RAM port
    logic              ram_en;
    logic              ram_we;
    logic [BDQ_AW-1:0] ram_addr;
    logic [BDQ_BW-1:0] ram_rdata;

    t_result           res_next;

    assign req_op      = t_op'(i_s_axis_tuser);
    assign req_byte    = i_s_axis_tdata[7:0];
    assign req_pos     = i_s_axis_tdata[15:8];
    assign req_pos_ext = BDQ_CW'(req_pos);

    // Stage 1 moves on when the output register is free or being drained.
    assign advance         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign is_full = (r_count == CountFull);
    assign is_none = (r_count == '0);

    // Decode: next pointer/count and the single RAM access of this request.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_use_rd = 1'b0;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_front;
        if (accept) begin
            unique case (req_op)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_front  = r_front - BDQ_AW'(1);
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = r_front - BDQ_AW'(1);
                        n_count  = r_count + BDQ_CW'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = r_front + r_count[BDQ_AW-1:0];
                        n_count  = r_count + BDQ_CW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (is_none) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_en   = 1'b1;
                        ram_addr = r_front;
                        n_use_rd = 1'b1;
                        n_front  = r_front + BDQ_AW'(1);
                        n_count  = r_count - BDQ_CW'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (is_none) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count  = r_count - BDQ_CW'(1);
                        ram_en   = 1'b1;
                        ram_addr = r_front + n_count[BDQ_AW-1:0];
                        n_use_rd = 1'b1;
                    end
                end
                OP_READ_AT: begin
                    if (req_pos_ext >= r_count) begin
                        n_status = ST_RANGE;
                    end else begin
                        ram_en   = 1'b1;
                        ram_addr = r_front + BDQ_AW'(req_pos);
                        n_use_rd = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_front = '0;
                    n_count = '0;
                end
                default: begin
                    // unused opcodes: no operation, status ok
                end
            endcase
        end
    end

    bdq_ram #(
        .WIDTH (BDQ_BW),
        .DEPTH (BDQ_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (req_byte),
        .o_rdata (ram_rdata)
    );

    // Result assembled from stage 1 and the RAM read data.
    always_comb begin
        res_next.read_byte = r_s1_use_rd ? ram_rdata : '0;
        res_next.status    = r_s1_status;
        res_next.count_now = r_s1_count;
        res_next.is_empty  = (r_s1_count == '0);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_count  <= n_count;
            r_s1_use_rd <= n_use_rd;
        end
        if (advance) begin
            r_out <= res_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = BDQ_OUT_W'(r_out);

endmodule

// ===== design/bdq_checker.sv =====
// Port-level checker for the byte deque, bound to the top level.
// Depends on bdq_pkg and byte_deque_with_indexed_read_defines.svh.
`include "byte_deque_with_indexed_read_defines.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [BDQ_IN_W-1:0]  i_s_axis_tdata,   // [7:0] push_byte, [15:8] position
    input logic [BDQ_OP_W-1:0]  i_s_axis_tuser,   // [2:0] opcode
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [BDQ_OUT_W-1:0] o_m_axis_tdata    // [7:0] read_byte, [9:8] status,
                                                   // [18:10] count_now, [19] is_empty
);

    // stalled result holds
    `BDQ_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // empty flag agrees with count
    `BDQ_ASSERT_NOW(a_empty_flag, o_m_axis_tvalid, o_m_axis_tdata[19] == (o_m_axis_tdata[18:10] == 9'd0), "is_empty disagrees with count_now")

    // failed request carries no byte
    `BDQ_ASSERT_NOW(a_err_zero, o_m_axis_tvalid && (o_m_axis_tdata[9:8] != ST_OK), o_m_axis_tdata[7:0] == 8'd0, "read_byte nonzero on error")

    // count bounded by capacity
    `BDQ_ASSERT_NOW(a_count_max, o_m_axis_tvalid, o_m_axis_tdata[18:10] <= BDQ_CW'(BDQ_DEPTH), "count_now above capacity")

endmodule

bind byte_deque_with_indexed_read bdq_checker u_bdq_checker (.*);

// ===== verif/tb.sv =====
// Self-checking bench for the byte deque: a scoreboard class that models the ring buffer,
// plus stream drivers with bursty requests and a patterned result stall.
// Depends on bdq_pkg and the byte_deque_with_indexed_read RTL.

class deque_scoreboard;
    logic [7:0]        ring [bdq_pkg::BDQ_DEPTH];   // mirror of the byte store
    logic [7:0]        head;                        // front pointer
    logic [8:0]        fill;                        // element count
    bdq_pkg::t_result  deque_answers [$];           // predicted results, oldest first
    int unsigned       requests_seen;
    int unsigned       answers_checked;
    int unsigned       mismatches;
    int unsigned       peak_fill;
    int unsigned       status_tally [4];

    function new();
        head = '0;
        fill = '0;
        requests_seen = 0;
        answers_checked = 0;
        mismatches = 0;
        peak_fill = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function void apply_request(logic [2:0] op, logic [7:0] data, logic [7:0] pos);
        bdq_pkg::t_result r;
        logic [7:0]       idx;
        r = '0;
        r.status = bdq_pkg::ST_OK;
        case (op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (fill == bdq_pkg::BDQ_DEPTH) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    head = head - 8'd1;
                    ring[head] = data;
                    fill = fill + 9'd1;
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (fill == bdq_pkg::BDQ_DEPTH) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    idx = head + fill[7:0];
                    ring[idx] = data;
                    fill = fill + 9'd1;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else begin
                    r.read_byte = ring[head];
                    head = head + 8'd1;
                    fill = fill - 9'd1;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (fill == 0) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else begin
                    fill = fill - 9'd1;
                    idx = head + fill[7:0];
                    r.read_byte = ring[idx];
                end
            end
            bdq_pkg::OP_READ_AT: begin
                if ({1'b0, pos} >= fill) begin
                    r.status = bdq_pkg::ST_RANGE;
                end else begin
                    idx = head + pos;
                    r.read_byte = ring[idx];
                end
            end
            bdq_pkg::OP_CLEAR: begin
                fill = '0;
                head = '0;
            end
            default: ;  // unused opcodes leave everything alone
        endcase
        r.count_now = fill;
        r.is_empty  = (fill == 0);
        if (fill > peak_fill) peak_fill = fill;
        status_tally[r.status]++;
        requests_seen++;
        deque_answers.insert(deque_answers.size(), r);
    endfunction

    function void report(string what, bdq_pkg::t_result want, bdq_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH (%s) at result %0d: want byte %02h st %0d cnt %0d empty %0b",
                     what, answers_checked, want.read_byte, want.status, want.count_now,
                     want.is_empty);
            $display("    got byte %02h st %0d cnt %0d empty %0b",
                     got.read_byte, got.status, got.count_now, got.is_empty);
        end
    endfunction

    function void check_answer(bdq_pkg::t_result got);
        bdq_pkg::t_result want;
        answers_checked++;
        if (deque_answers.size() == 0) begin
            want = '0;
            report("no request waiting", want, got);
        end else begin
            want = deque_answers[0];
            deque_answers.delete(0);
            if (got.read_byte !== want.read_byte || got.status !== want.status ||
                got.count_now !== want.count_now || got.is_empty !== want.is_empty)
                report("field", want, got);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdq_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;     // margin after the last result is checked

    // Opcodes the block treats as no-ops.
    localparam logic [BDQ_OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [BDQ_OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Result-side ready patterns.
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_EVERY_THIRD,
        RX_LONG_STALL
    } t_rx_pattern;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [BDQ_IN_W-1:0]  i_s_axis_tdata  = '0;   // [7:0] push_byte, [15:8] position
    logic [BDQ_OP_W-1:0]  i_s_axis_tuser  = '0;   // [2:0] opcode
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [BDQ_OUT_W-1:0] o_m_axis_tdata;         // [7:0] read_byte, [9:8] status,
                                                  // [18:10] count_now, [19] is_empty

    deque_scoreboard sb = new();

    int unsigned burst_left  = 1;   // requests left in the current sender burst
    int unsigned sent_count  = 0;
    int unsigned idle_cycles = 0;
    t_rx_pattern rx_mode     = RX_OPEN;
    int unsigned rx_left     = 0;
    int unsigned rx_phase    = 0;

    byte_deque_with_indexed_read dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Present one request, hold it until the handshake, then hand it to the
    // scoreboard. Handshakes are sampled at the edge with pre-edge values.
    // Ends a burst with a random gap; valid stays high between requests of a burst.
    task automatic issue(input logic [BDQ_OP_W-1:0] op, input logic [7:0] data,
                         input logic [7:0] pos);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {pos, data};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.apply_request(op, data, pos);
        sent_count++;
        burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Read positions: mostly in range, some exactly at the count, some anywhere.
    function automatic logic [7:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.fill != 0 && r < 60)
            return 8'($urandom_range(0, sb.fill - 1));
        else if (r < 75 && sb.fill < BDQ_DEPTH)
            return sb.fill[7:0];
        return 8'($urandom_range(0, 255));
    endfunction

    // Push from either end until full, then knock on the full store and
    // read the last slot.
    task automatic fill_to_full();
        while (sb.fill < BDQ_DEPTH) begin
            if ($urandom_range(0, 19) == 0)
                issue(OP_READ_AT, 8'($urandom), pick_position());
            else
                issue($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      8'($urandom), 8'($urandom));
        end
        repeat (3)
            issue($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                  8'($urandom), 8'($urandom));
        issue(OP_READ_AT, 8'($urandom), 8'd255);
        issue(OP_READ_AT, 8'($urandom), pick_position());
    endtask

    // Pop from either end until empty, then pop a couple more.
    task automatic drain_to_empty();
        while (sb.fill != 0) begin
            if ($urandom_range(0, 9) == 0)
                issue(OP_READ_AT, 8'($urandom), pick_position());
            else
                issue($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
                      8'($urandom), 8'($urandom));
        end
        repeat (2)
            issue($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
                  8'($urandom), 8'($urandom));
    endtask

    // Mixed traffic with a little noise: clears and unused opcodes.
    task automatic mixed_run(input int unsigned n);
        int unsigned w;
        repeat (n) begin
            w = $urandom_range(0, 99);
            if (w < 20)      issue(OP_PUSH_FRONT, 8'($urandom), 8'($urandom));
            else if (w < 40) issue(OP_PUSH_BACK, 8'($urandom), 8'($urandom));
            else if (w < 55) issue(OP_POP_FRONT, 8'($urandom), 8'($urandom));
            else if (w < 70) issue(OP_POP_BACK, 8'($urandom), 8'($urandom));
            else if (w < 92) issue(OP_READ_AT, 8'($urandom), pick_position());
            else if (w < 96) issue(OP_CLEAR, 8'($urandom), 8'($urandom));
            else issue($urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO,
                       8'($urandom), 8'($urandom));
        end
    endtask

    // Result side: check every accepted result, then pick next cycle's ready
    // from the current stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_answer(t_result'(o_m_axis_tdata[BDQ_RES_W-1:0]));
        if (rx_left == 0) begin
            rx_mode  = t_rx_pattern'($urandom_range(0, 4));
            rx_left  = $urandom_range(8, 80);
            rx_phase = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:        i_m_axis_tready <= 1'b1;
            RX_MOSTLY:      i_m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE:      i_m_axis_tready <= ($urandom_range(0, 9) < 3);
            RX_EVERY_THIRD: i_m_axis_tready <= (rx_phase % 3 == 0);
            default:        i_m_axis_tready <= (rx_phase % 13 == 0);  // long stalls
        endcase
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.deque_answers.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int unsigned directed_sent;
        int unsigned pick;

        // Synchronous reset held from time zero, then released once.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-store errors, unused opcodes, pushes at both ends
        // with extreme bytes, reads at front, last, count and far out of
        // range, clear, front pointer wrapping below zero, and a pop from the
        // back of a one-element store.
        issue(OP_POP_FRONT, 8'h00, 8'h00);
        issue(OP_POP_BACK, 8'hFF, 8'hFF);
        issue(OP_READ_AT, 8'h00, 8'h00);
        issue(OP_UNUSED_LO, 8'hFF, 8'hFF);
        issue(OP_UNUSED_HI, 8'h55, 8'hAA);
        issue(OP_PUSH_BACK, 8'hFF, 8'h00);
        issue(OP_PUSH_FRONT, 8'h00, 8'hFF);
        issue(OP_PUSH_BACK, 8'hA5, 8'h5A);
        issue(OP_PUSH_FRONT, 8'h5A, 8'hA5);
        issue(OP_READ_AT, 8'hFF, 8'd0);
        issue(OP_READ_AT, 8'h00, 8'd3);
        issue(OP_READ_AT, 8'h00, 8'd4);
        issue(OP_READ_AT, 8'h00, 8'd255);
        issue(OP_POP_BACK, 8'h00, 8'h00);
        issue(OP_POP_FRONT, 8'h00, 8'h00);
        issue(OP_CLEAR, 8'hFF, 8'hFF);
        issue(OP_POP_BACK, 8'h00, 8'h00);
        issue(OP_PUSH_FRONT, 8'h3C, 8'h00);
        issue(OP_POP_BACK, 8'h00, 8'h00);
        issue(OP_PUSH_BACK, 8'h81, 8'h00);
        issue(OP_POP_FRONT, 8'h00, 8'h00);
        issue(OP_PUSH_FRONT, 8'h7E, 8'h00);
        issue(OP_READ_AT, 8'h00, 8'd0);
        issue(OP_CLEAR, 8'h00, 8'h00);
        directed_sent = sent_count;

        // Random: start with a fill to full so the full and last-slot cases
        // always appear, then segments of filling, draining and mixed traffic.
        fill_to_full();
        while (sent_count < directed_sent + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      fill_to_full();
            else if (pick < 25) drain_to_empty();
            else                mixed_run($urandom_range(10, 50));
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.deque_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d results; ok/empty/range/full = %0d/%0d/%0d/%0d",
                 sb.requests_seen, sb.answers_checked, sb.status_tally[ST_OK],
                 sb.status_tally[ST_EMPTY], sb.status_tally[ST_RANGE],
                 sb.status_tally[ST_FULL]);
        $display("peak fill %0d of %0d entries, %0d mismatching results",
                 sb.peak_fill, BDQ_DEPTH, sb.mismatches);
        if (sb.mismatches == 0 && sb.deque_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
